// File: rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: invariant");

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");

`endif

// File: rtl/etl_pkg.sv
package etl_pkg;

	// Result field widths
	localparam int TOKEN_VALUE_BITS = 31;
	localparam int TOKEN_KIND_BITS  = 3;

	// Job queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Token kinds
	typedef enum logic [TOKEN_KIND_BITS-1:0] {
		TK_INT   = 3'd0,
		TK_ADD   = 3'd1,
		TK_MUL   = 3'd2,
		TK_OPEN  = 3'd3,
		TK_CLOSE = 3'd4,
		TK_BAD   = 3'd5,
		TK_OVF   = 3'd6,
		TK_END   = 3'd7
	} token_kind_t;

	// One queued job: optional integer token, then optional single-kind token
	typedef struct packed {
		logic                        has_int;
		logic [TOKEN_VALUE_BITS-1:0] int_val;
		logic                        has_op;
		token_kind_t                 op_kind;
	} etl_job_t;

	// Queue control: push from the front and the full status it sees
	typedef struct packed {
		logic push;
		logic full;
	} etl_qctl_t;

endpackage

// File: rtl/etl_front.sv
module etl_front #(
	parameter int NUMBER_BITS = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_char,
	input  logic             in_end,
	input  logic             q_full,
	output logic             in_ready,
	output logic             push,
	output etl_pkg::etl_job_t job
);
	import etl_pkg::*;

	logic                   in_number_q;
	logic                   skipping_q;
	logic [NUMBER_BITS-1:0] acc_q;

	logic                   accept;
	logic [NUMBER_BITS+3:0] prod;
	logic                   ovf;
	logic                   emit;
	logic                   nxt_in_number;
	logic                   nxt_skipping;
	logic [NUMBER_BITS-1:0] nxt_acc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// acc * 10 + digit as shift-add, overflow when any bit above the range is set
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ (NUMBER_BITS+4)'(in_char[3:0]);
	assign ovf  = |prod[NUMBER_BITS+3:NUMBER_BITS];

	// Classify the character and build the job
	always_comb begin
		emit          = 1'b0;
		job.has_int   = in_number_q;
		job.int_val   = TOKEN_VALUE_BITS'(acc_q);
		job.has_op    = 1'b0;
		job.op_kind   = TK_END;
		nxt_in_number = in_number_q;
		nxt_skipping  = skipping_q;
		nxt_acc       = acc_q;
		if (in_end) begin
			job.has_int   = in_number_q && !skipping_q;
			job.has_op    = 1'b1;
			job.op_kind   = TK_END;
			emit          = 1'b1;
			nxt_in_number = 1'b0;
			nxt_skipping  = 1'b0;
			nxt_acc       = '0;
		end else if (!skipping_q) begin
			unique case (in_char) inside
				[CH_ZERO:CH_NINE]: begin
					if (ovf) begin
						job.has_int   = 1'b0;
						job.has_op    = 1'b1;
						job.op_kind   = TK_OVF;
						emit          = 1'b1;
						nxt_in_number = 1'b0;
						nxt_skipping  = 1'b1;
						nxt_acc       = '0;
					end else begin
						nxt_in_number = 1'b1;
						nxt_acc       = prod[NUMBER_BITS-1:0];
					end
				end
				CH_SPACE: begin
					emit          = in_number_q;
					nxt_in_number = 1'b0;
					nxt_acc       = '0;
				end
				CH_PLUS, CH_STAR, CH_OPEN, CH_CLOSE: begin
					job.has_op    = 1'b1;
					emit          = 1'b1;
					nxt_in_number = 1'b0;
					nxt_acc       = '0;
					unique case (in_char)
						CH_PLUS:  job.op_kind = TK_ADD;
						CH_STAR:  job.op_kind = TK_MUL;
						CH_OPEN:  job.op_kind = TK_OPEN;
						default:  job.op_kind = TK_CLOSE;
					endcase
				end
				default: begin
					// bad character: pending number dropped
					job.has_int   = 1'b0;
					job.has_op    = 1'b1;
					job.op_kind   = TK_BAD;
					emit          = 1'b1;
					nxt_in_number = 1'b0;
					nxt_skipping  = 1'b1;
					nxt_acc       = '0;
				end
			endcase
		end
	end

	assign push = accept && emit;

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_number_q <= 1'b0;
			skipping_q  <= 1'b0;
			acc_q       <= '0;
		end else if (accept) begin
			in_number_q <= nxt_in_number;
			skipping_q  <= nxt_skipping;
			acc_q       <= nxt_acc;
		end
	end

endmodule

// File: rtl/etl_queue.sv
module etl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  etl_pkg::etl_qctl_t ctl,
	input  etl_pkg::etl_job_t wr_job,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output etl_pkg::etl_job_t rd_job
);
	import etl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	etl_job_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_pop;

	assign full      = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_pop    = pop && not_empty;
	assign rd_job    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({ctl.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/etl_back.sv
module etl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  etl_pkg::etl_job_t job,
	output logic              pop,
	output logic              tok_valid,
	input  logic              tok_ready,
	output logic [2:0]        tok_kind,
	output logic [30:0]       tok_value,
	output logic              tok_last
);
	import etl_pkg::*;

	// Set once the integer token of the head job has been sent
	logic int_done_q;
	logic show_int;
	logic xfer;

	assign show_int  = job.has_int && !int_done_q;
	assign tok_valid = job_valid;
	assign tok_kind  = show_int ? TK_INT : job.op_kind;
	assign tok_value = show_int ? job.int_val : '0;
	assign tok_last  = show_int ? !job.has_op : 1'b1;
	assign xfer      = tok_valid && tok_ready;
	assign pop       = xfer && tok_last;

	// Token phase within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_done_q <= 1'b0;
		end else if (pop) begin
			int_done_q <= 1'b0;
		end else if (xfer) begin
			int_done_q <= 1'b1;
		end
	end

endmodule

// File: rtl/expression_token_lexer_unit.sv
// Expression token lexer.
// Input stream s_axis: one character per transfer in s_axis_tdata[7:0];
// s_axis_tlast marks the end of the expression (the byte is then ignored).
// Output stream m_axis: one token per transfer; m_axis_tuser[2:0] is the kind
// (integer, add, multiply, open, close, bad char, overflow, end),
// m_axis_tdata[30:0] the integer value (zero for other kinds), and
// m_axis_tlast flags the last token caused by one input character.
// Digits accumulate with no output; the number is sent when a space,
// operator, parenthesis or end marker follows. After a bad character or an
// overflow, input is dropped until the end marker.
// Throughput: one character per cycle while the queue is not full; the front
// classifies and accumulates in the accepting cycle and writes a job into a
// 4-entry queue. The back sends one token per cycle while the receiver is
// ready, so a character that yields two tokens makes two transfers.
// Reset clears the lexer state and empties the queue. When the receiver
// stalls, the queue fills and s_axis_tready drops; no token is lost.
module expression_token_lexer_unit #(
	parameter int NUMBER_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tlast,  // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [30:0] token_value, [31] zero
	output logic [2:0]  m_axis_tuser,  // [2:0] token_kind
	output logic        m_axis_tlast   // last_of_run
);
	import etl_pkg::*;

	etl_job_t  front_job;
	etl_job_t  head_job;
	etl_qctl_t qctl;
	logic      push;
	logic      pop;
	logic      head_valid;
	logic      q_full;
	logic [TOKEN_VALUE_BITS-1:0] tok_value;

	assign qctl.push = push;
	assign qctl.full = q_full;

	etl_front #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_char  (s_axis_tdata),
		.in_end   (s_axis_tlast),
		.q_full   (qctl.full),
		.in_ready (s_axis_tready),
		.push     (push),
		.job      (front_job)
	);

	etl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (qctl),
		.wr_job    (front_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (head_valid),
		.rd_job    (head_job)
	);

	etl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.tok_valid (m_axis_tvalid),
		.tok_ready (m_axis_tready),
		.tok_kind  (m_axis_tuser),
		.tok_value (tok_value),
		.tok_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, tok_value};

endmodule

// File: rtl/etl_checker.sv
`include "assert_macros.svh"

module etl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import etl_pkg::*;

	// Whole token word as seen on the output stream
	logic [35:0] m_word;

	assign m_word = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

	// A stalled token holds until it is taken
	`ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_word))

	// Only integer tokens carry a value
	`ASSERT_ALWAYS(a_value_zero, !m_axis_tvalid || m_axis_tuser == TK_INT || m_axis_tdata == '0)

	// Every non-integer token closes the tokens of its character
	`ASSERT_ALWAYS(a_op_last, !m_axis_tvalid || m_axis_tuser == TK_INT || m_axis_tlast)

	// Spare top data bit stays clear
	`ASSERT_ALWAYS(a_pad_zero, !m_axis_tvalid || !m_axis_tdata[31])

endmodule

bind expression_token_lexer_unit etl_checker u_etl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// File: verif/etl_token_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the lexer, predicts the token stream from the
// accepted characters and compares every token transfer in order.
module etl_token_checker
	import etl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [7:0]  s_data,
	input  logic        s_last,
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [31:0] m_data,
	input  logic [2:0]  m_user,
	input  logic        m_last,
	output int          fail_count,
	output int          tokens_pending
);

	typedef struct {
		token_kind_t                 kind;
		logic [TOKEN_VALUE_BITS-1:0] value;
		logic                        last;
	} token_t;

	token_t            expected_tokens[$];
	token_t            want;
	logic              in_number;
	logic              skipping;
	longint unsigned   number_value;

	// Lexer state update for one character transfer; queues the tokens it causes
	task automatic lex_char(input logic [7:0] ch, input logic eoi);
		token_kind_t                 kinds[2];
		logic [TOKEN_VALUE_BITS-1:0] vals[2];
		longint unsigned             digit;
		longint unsigned             acc;
		longint unsigned             limit;
		token_kind_t                 op;
		logic                        has_op;
		logic                        is_sep;
		token_t                      tok;
		int                          n;
		int                          i;
		n = 0;
		op = TK_END;
		has_op = 1'b1;
		is_sep = 1'b1;
		limit = (64'd1 << TOKEN_VALUE_BITS) - 1;
		if (eoi) begin
			// end marker: flush a pending number unless dropping input
			if (!skipping && in_number) begin
				kinds[n] = TK_INT;
				vals[n] = number_value[TOKEN_VALUE_BITS-1:0];
				n++;
			end
			kinds[n] = TK_END;
			vals[n] = '0;
			n++;
			in_number = 1'b0;
			number_value = 0;
			skipping = 1'b0;
		end else if (!skipping) begin
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				digit = ch - CH_ZERO;
				acc = in_number ? number_value : 0;
				if (acc > (limit - digit) / 10) begin
					// value would leave the number range
					kinds[n] = TK_OVF;
					vals[n] = '0;
					n++;
					in_number = 1'b0;
					number_value = 0;
					skipping = 1'b1;
				end else begin
					number_value = acc * 10 + digit;
					in_number = 1'b1;
				end
			end else begin
				case (ch)
					CH_SPACE: has_op = 1'b0;
					CH_PLUS:  op = TK_ADD;
					CH_STAR:  op = TK_MUL;
					CH_OPEN:  op = TK_OPEN;
					CH_CLOSE: op = TK_CLOSE;
					default:  is_sep = 1'b0;
				endcase
				if (!is_sep) begin
					// bad character drops the pending number
					kinds[n] = TK_BAD;
					vals[n] = '0;
					n++;
					in_number = 1'b0;
					number_value = 0;
					skipping = 1'b1;
				end else begin
					if (in_number) begin
						kinds[n] = TK_INT;
						vals[n] = number_value[TOKEN_VALUE_BITS-1:0];
						n++;
						in_number = 1'b0;
						number_value = 0;
					end
					if (has_op) begin
						kinds[n] = op;
						vals[n] = '0;
						n++;
					end
				end
			end
		end
		for (i = 0; i < n; i++) begin
			tok.kind = kinds[i];
			tok.value = vals[i];
			tok.last = (i == n - 1);
			expected_tokens = {expected_tokens, tok};
		end
	endtask

	// Predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tokens.delete();
			in_number = 1'b0;
			skipping = 1'b0;
			number_value = 0;
			fail_count = 0;
			tokens_pending <= 0;
		end else begin
			if (s_valid && s_ready)
				lex_char(s_data, s_last);
			if (m_valid && m_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token: kind %0d value %0d last %0b",
						m_user, m_data, m_last);
					fail_count++;
				end else begin
					want = expected_tokens.pop_front();
					if (m_user !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, m_user);
						fail_count++;
					end
					if (m_data !== 32'(want.value)) begin
						$error("token_value: expected %0d, got %0d", want.value, m_data);
						fail_count++;
					end
					if (m_last !== want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last, m_last);
						fail_count++;
					end
				end
			end
			tokens_pending <= expected_tokens.size();
		end
	end

endmodule

// File: verif/expression_token_lexer_unit_tb.sv
`timescale 1ns / 100ps

module expression_token_lexer_unit_tb;
	import etl_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_EVERY  = 400;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int failures;
	int tokens_pending;
	int sent_items;
	int idle_cycles;
	int rx_hold;
	bit steady;

	expression_token_lexer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	etl_token_checker token_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_valid        (s_axis_tvalid),
		.s_ready        (s_axis_tready),
		.s_data         (s_axis_tdata),
		.s_last         (s_axis_tlast),
		.m_valid        (m_axis_tvalid),
		.m_ready        (m_axis_tready),
		.m_data         (m_axis_tdata),
		.m_user         (m_axis_tuser),
		.m_last         (m_axis_tlast),
		.fail_count     (failures),
		.tokens_pending (tokens_pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Mostly short gaps, a few long ones; none in steady stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Byte that is no digit, space, operator or parenthesis
	function automatic logic [7:0] pick_bad();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE || b == CH_PLUS ||
			b == CH_STAR || b == CH_OPEN || b == CH_CLOSE);
		return b;
	endfunction

	// One character transfer, after a random gap
	task automatic send_item(input logic [7:0] ch, input logic eoi);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= eoi;
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
	endtask

	task automatic send_text(input string text);
		int i;
		for (i = 0; i < text.len(); i++)
			send_item(text[i], 1'b0);
	endtask

	// Hold off the sender until every predicted token has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0) @(posedge clk);
	endtask

	// Operand value: mostly short, sometimes around the top of the range
	function automatic longint unsigned pick_number();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return $urandom_range(0, 999);
		if (r < 13)
			return $urandom_range(0, 9);
		if (r < 16)
			return {32'd0, $urandom};
		if (r == 16)
			return 64'd2147483647 - $urandom_range(0, 9);
		if (r == 17)
			return 64'd2147483648 + $urandom_range(0, 9);
		if (r == 18)
			return 64'd21474836470 + $urandom_range(0, 9);
		return {32'd0, $urandom} * 64'd10 + $urandom_range(0, 9);
	endfunction

	// One expression: well-formed tokens with random content, now and then
	// broken by a bad byte or left without an end marker; some pure noise
	task automatic send_expression();
		int n_tok;
		int k;
		int pick;
		steady = ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 9) == 0) begin
			n_tok = $urandom_range(1, 8);
			for (k = 0; k < n_tok; k++)
				send_item(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			n_tok = $urandom_range(1, 12);
			for (k = 0; k < n_tok; k++) begin
				pick = $urandom_range(0, 19);
				if (pick < 8) begin
					if ($urandom_range(0, 9) == 0)
						send_item(CH_ZERO, 1'b0);
					send_text($sformatf("%0d", pick_number()));
				end else if (pick < 10)
					send_item(CH_PLUS, 1'b0);
				else if (pick < 12)
					send_item(CH_STAR, 1'b0);
				else if (pick < 14)
					send_item(CH_OPEN, 1'b0);
				else if (pick < 16)
					send_item(CH_CLOSE, 1'b0);
				else if (pick < 19)
					send_item(CH_SPACE, 1'b0);
				else if ($urandom_range(0, 3) == 0)
					send_item(pick_bad(), 1'b0);
				else
					send_item(CH_SPACE, 1'b0);
			end
		end
		if ($urandom_range(0, 99) < 85)
			send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Receiver: random stall bursts on the token side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("** expression_token_lexer_unit: FAILED **");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stop_at;
		int next_drain;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		sent_items = 0;
		steady = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: number then operator, parens, spaces alone and after a number
		send_text("12+(3)* 7 ");
		// largest value flushed by the end marker
		send_text("2147483647");
		send_item(8'h00, 1'b1);
		// overflow on the first digit past the range, rest dropped
		send_text("21474836470)");
		send_item(8'hFF, 1'b1);
		// high byte is a bad character, then dropped input
		send_item(8'hFF, 1'b0);
		send_item(CH_PLUS, 1'b0);
		send_item(8'h7F, 1'b1);
		drain();

		// Random expressions
		stop_at = sent_items + RANDOM_ITEMS;
		next_drain = sent_items + DRAIN_EVERY;
		while (sent_items < stop_at) begin
			send_expression();
			if (sent_items >= next_drain) begin
				drain();
				next_drain = sent_items + DRAIN_EVERY;
			end
		end
		drain();
		repeat (8) @(posedge clk);

		if (failures == 0)
			$display("** expression_token_lexer_unit: PASSED **");
		else
			$display("** expression_token_lexer_unit: FAILED **");
		$finish;
	end

endmodule
